[hw/rtl/ittw_pkg.sv]
package ittw_pkg;

  localparam int unsigned CHAN_W    = 6;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned MAX_SLOTS = 16;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [ADDR_W-1:0] ADDR_WHEEL_SLOTS = 3'd0;
  localparam logic [CFG_W-1:0]  WHEEL_SLOTS_RST  = 5'd8;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic {
    OP_REFRESH = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef struct packed {
    op_e   op;
    chan_t channel;
  } cmd_t;

endpackage

[hw/rtl/idle_timeout_timing_wheel.sv]
// Refresh: one word per cycle sustained while the back end is idle; accepted into a
//   two-entry queue and applied by the back end at the edge it leaves the queue.
// Tick: the back end scans the channel table channel by channel (memory read, then
//   compare) and waits while the output side stalls before it emits a word;
//   each expiry word waits for the next hit or the end of the scan, which settles
//   its last flag.
// Reset: no channel tracked, current slot 0, wheel_slots 8, queue empty.
module idle_timeout_timing_wheel #(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [5:0]                     channel_id_i,
  input  logic                           exempt_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [5:0]                     expired_channel_o,
  output logic                           last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ittw_pkg::ADDR_W-1:0]    paddr,
  input  logic [ittw_pkg::DATA_W-1:0]    pwdata,
  output logic [ittw_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  logic [ittw_pkg::CFG_W-1:0] wheel_slots_q;
  logic                       cfg_wr;
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_valid;
  ittw_pkg::cmd_t             q_push_cmd;
  ittw_pkg::cmd_t             q_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ittw_pkg::ADDR_WHEEL_SLOTS);
  assign prdata = (paddr == ittw_pkg::ADDR_WHEEL_SLOTS) ?
                  ittw_pkg::DATA_W'(wheel_slots_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_slots_q <= ittw_pkg::WHEEL_SLOTS_RST;
    end else if (cfg_wr) begin
      wheel_slots_q <= pwdata[ittw_pkg::CFG_W-1:0];
    end
  end

  ittw_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .channel_id_i (channel_id_i),
    .exempt_i     (exempt_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_push_cmd)
  );

  ittw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  ittw_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (q_valid),
    .cmd_i             (q_cmd),
    .cmd_pop_o         (q_pop),
    .wheel_slots_i     (wheel_slots_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .expired_channel_o (expired_channel_o),
    .last_o            (last_o)
  );

endmodule

[hw/rtl/ittw_front.sv]
module ittw_front #(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           operation_i,
  input  logic [5:0]     channel_id_i,
  input  logic           exempt_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output ittw_pkg::cmd_t q_cmd_o
);

  logic in_range;
  logic keep;

  // drop exempt refreshes and refreshes to channels beyond the table
  assign in_range   = {1'b0, channel_id_i} < 7'(MAX_CHANNELS);
  assign keep       = (operation_i == ittw_pkg::OP_TICK) || (!exempt_i && in_range);
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

  assign q_cmd_o.op      = ittw_pkg::op_e'(operation_i);
  assign q_cmd_o.channel = channel_id_i;

endmodule

[hw/rtl/ittw_queue.sv]
module ittw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ittw_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ittw_pkg::cmd_t cmd_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ittw_pkg::cmd_t  entries [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign cmd_o   = entries[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[hw/rtl/ittw_back.sv]
module ittw_back #(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  ittw_pkg::cmd_t                  cmd_i,
  output logic                            cmd_pop_o,
  input  logic [ittw_pkg::CFG_W-1:0]      wheel_slots_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ittw_pkg::chan_t                 expired_channel_o,
  output logic                            last_o
);

  localparam int unsigned IdxW = $clog2(MAX_CHANNELS);

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_FLUSH = 4'b1000
  } back_state_e;

  back_state_e             state_q, state_d;
  logic [MAX_CHANNELS-1:0] valid_q, valid_d;
  ittw_pkg::slot_t         slot_mem [MAX_CHANNELS];
  ittw_pkg::slot_t         rdata_q;
  ittw_pkg::slot_t         cur_q, cur_d;
  idx_t                    idx_q, idx_d;
  idx_t                    pend_q, pend_d;
  logic                    pend_valid_q, pend_valid_d;
  logic                    out_valid_q, out_valid_d;
  ittw_pkg::chan_t         out_chan_q, out_chan_d;
  logic                    out_last_q, out_last_d;
  logic                    mem_we;
  logic                    mem_re;
  idx_t                    wr_idx;
  logic                    can_emit;
  logic                    hit;
  logic                    scan_done;
  logic [ittw_pkg::CFG_W-1:0] eff_slots;
  logic [ittw_pkg::CFG_W-1:0] cur_plus;
  ittw_pkg::slot_t         next_slot;

  always_comb begin
    if (wheel_slots_i == '0) begin
      eff_slots = ittw_pkg::CFG_W'(1);
    end else if (wheel_slots_i > ittw_pkg::CFG_W'(ittw_pkg::MAX_SLOTS)) begin
      eff_slots = ittw_pkg::CFG_W'(ittw_pkg::MAX_SLOTS);
    end else begin
      eff_slots = wheel_slots_i;
    end
  end

  assign cur_plus  = {1'b0, cur_q} + ittw_pkg::CFG_W'(1);
  assign next_slot = (cur_plus >= eff_slots) ? '0 : cur_plus[ittw_pkg::SLOT_W-1:0];

  assign wr_idx    = cmd_i.channel[IdxW-1:0];
  assign can_emit  = !out_valid_q || !out_stall_i;
  assign hit       = valid_q[idx_q] && (rdata_q == cur_q);
  assign scan_done = idx_q == idx_t'(MAX_CHANNELS - 1);

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_chan_d   = out_chan_q;
    out_last_d   = out_last_q;
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == ittw_pkg::OP_TICK) begin
            cur_d   = next_slot;
            idx_d   = '0;
            state_d = ST_READ;
          end else begin
            mem_we          = 1'b1;
            valid_d[wr_idx] = 1'b1;
          end
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!(hit && pend_valid_q && !can_emit)) begin
          if (hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_chan_d  = ittw_pkg::chan_t'(pend_q);
              out_last_d  = 1'b0;
            end
            pend_d         = idx_q;
            pend_valid_d   = 1'b1;
            valid_d[idx_q] = 1'b0;
          end
          if (scan_done) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_emit) begin
          out_valid_d  = 1'b1;
          out_chan_d   = ittw_pkg::chan_t'(pend_q);
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      cur_q        <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      cur_q        <= cur_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_chan_q <= out_chan_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[wr_idx] <= cur_q;
    end
    if (mem_re) begin
      rdata_q <= slot_mem[idx_q];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign expired_channel_o = out_chan_q;
  assign last_o            = out_last_q;

endmodule

[hw/rtl/ittw_checker.sv]
module ittw_checker #(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [5:0]                  expired_channel_o,
  input logic                        last_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [ittw_pkg::ADDR_W-1:0] paddr,
  input logic [ittw_pkg::DATA_W-1:0] pwdata,
  input logic [ittw_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);

  logic cfg_wr0;

  assign cfg_wr0 = psel && penable && pwrite && pready &&
                   (paddr == ittw_pkg::ADDR_WHEEL_SLOTS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(expired_channel_o) && $stable(last_o))
    else $error("stalled output word changed");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, expired_channel_o} < 7'(MAX_CHANNELS)))
    else $error("expired channel beyond table");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr0 ##1 (paddr == ittw_pkg::ADDR_WHEEL_SLOTS) |->
      (prdata[ittw_pkg::CFG_W-1:0] == $past(pwdata[ittw_pkg::CFG_W-1:0])))
    else $error("wheel_slots readback mismatch");

endmodule

bind idle_timeout_timing_wheel ittw_checker #(
  .MAX_CHANNELS(MAX_CHANNELS)
) u_checker (.*);
